### design/hmm_pkg.sv
// Shared types and codes for the histogram matching mapper.
package hmm_pkg;

  localparam int LEVEL_W  = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [CMD_W-1:0] CMD_SRC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TGT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_EQ_RD,
    S_EQ_ACC,
    S_EQ_MUL,
    S_EQ_START,
    S_EQ_DIV,
    S_FILL,
    S_TAIL,
    S_Q_RD1,
    S_Q_RD2,
    S_Q_RD3,
    S_OUT
  } hmm_state_t;

endpackage

### design/histogram_matching_mapper_unit.sv
// Top level of the histogram matching mapper: sequencer, count and table memories.
//
// Usage: requests arrive on the in_valid/in_ready channel. Command 0 writes a
// source bin, command 1 a target bin; each gives no result. Command 3 is dropped.
// Command 2 queries the matched level of a source gray level and gives one result
// on the out_valid/out_ready channel. The user must write the levels_in_use
// register through cfg_we/cfg_wdata only while idle; the block does not check.
//
// Any bin write or register write marks the tables stale. The next in-range
// query then runs a recompute pass: a totals sweep, an equalize pass for
// both histograms with one divide per bin, and the fill of the level map.
// With current tables a query reads the table memory twice, in states
// S_Q_RD1 to S_Q_RD3, before the output state loads the result register;
// an out-of-range query, or one against a zero total, goes straight to the
// output state. A new query is taken only once the sequencer is back in
// idle, after the two dependent reads of the table memory for a full query.
//
// Reset clears the control state and sets levels_in_use to 256; the counts
// must be written before use. When the receiver stalls, a finished result
// waits in the output register and bin writes are still taken; a further
// query is taken and computed, then holds the sequencer in its output state,
// blocking new requests, until the waiting result is taken.
module histogram_matching_mapper_unit #(
  parameter int MAX_LEVELS = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hmm_pkg::CMD_W-1:0]     command,
  input  logic [hmm_pkg::LEVEL_W-1:0]   level,
  input  logic [COUNT_BITS-1:0]         count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hmm_pkg::LEVEL_W-1:0]   source_level,
  output logic [hmm_pkg::LEVEL_W-1:0]   equalized_level,
  output logic [hmm_pkg::LEVEL_W-1:0]   matched_level,
  output logic [hmm_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_we,
  input  logic [hmm_pkg::CFG_W-1:0]     cfg_wdata
);
  import hmm_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEVELS);
  localparam int AW    = IDX_W + 1;
  localparam int CW    = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam int XW    = (IDX_W > LEVEL_W) ? IDX_W : LEVEL_W;
  localparam int TOT_W = COUNT_BITS + IDX_W;
  localparam int NUM_W = TOT_W + IDX_W + 2;

  hmm_state_t state, state_next;
  logic div_start;
  logic div_done;

  logic [CFG_W-1:0]    lvl_cfg;
  logic                tables_current;
  logic                totals_ok;
  logic                tbl;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W:0]      vptr;
  logic [IDX_W-1:0]    p;
  logic [TOT_W-1:0]    src_tot;
  logic [TOT_W-1:0]    tgt_tot;
  logic [TOT_W-1:0]    cum;
  logic [NUM_W-1:0]    num;
  logic [TOT_W:0]      den;
  logic [IDX_W-1:0]    q_idx;
  logic [IDX_W-1:0]    q_v;
  logic [LEVEL_W-1:0]  q_level;
  logic [LEVEL_W-1:0]  res_eq;
  logic [LEVEL_W-1:0]  res_match;
  logic [STATUS_W-1:0] res_status;

  logic [IDX_W-1:0]    div_q;
  logic [CW-1:0]       cfg_x;
  logic [CW-1:0]       lvl_x;
  logic [IDX_W:0]      n_act;
  logic [IDX_W-1:0]    nm1;
  logic                acc;
  logic                is_write;
  logic                range_bad;
  logic                last_idx;
  logic [TOT_W-1:0]    cnt_rd_x;
  logic [TOT_W-1:0]    tgt_sum;
  logic                zero_tot;
  logic                fill_go;
  logic                tail_go;
  logic [IDX_W-1:0]    fv;
  logic [IDX_W-1:0]    fill_val;
  logic [IDX_W-1:0]    dj;
  logic [IDX_W-1:0]    dp;
  logic [XW-1:0]       eq_x;
  logic [XW-1:0]       match_x;

  logic                cnt_we;
  logic [AW-1:0]       cnt_waddr;
  logic [AW-1:0]       cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                eq_we;
  logic [AW-1:0]       eq_waddr;
  logic [IDX_W-1:0]    eq_wdata;
  logic [AW-1:0]       eq_raddr;
  logic [IDX_W-1:0]    eq_rd;

  // Active level count: the register clamped to the range 2 to MAX_LEVELS.
  assign cfg_x = CW'(lvl_cfg);
  always_comb begin
    if (cfg_x < CW'(2)) begin
      n_act = (IDX_W + 1)'(2);
    end else if (cfg_x > CW'(MAX_LEVELS)) begin
      n_act = (IDX_W + 1)'(MAX_LEVELS);
    end else begin
      n_act = cfg_x[IDX_W:0];
    end
  end
  assign nm1 = IDX_W'(n_act - (IDX_W + 1)'(1));

  assign lvl_x     = CW'(level);
  assign acc       = in_valid && in_ready;
  assign is_write  = (command == CMD_SRC) || (command == CMD_TGT);
  assign range_bad = (lvl_x >= CW'(n_act));
  assign last_idx  = (idx == nm1);

  // Bin writes go straight to the count memory; bins beyond the store drop.
  assign cnt_we    = acc && is_write && (lvl_x < CW'(MAX_LEVELS));
  assign cnt_waddr = {command == CMD_TGT, IDX_W'(level)};
  assign cnt_raddr = {tbl, idx};

  assign cnt_rd_x = TOT_W'(cnt_rd);
  assign tgt_sum  = tgt_tot + cnt_rd_x;
  assign zero_tot = (src_tot == '0) || (tgt_sum == '0);

  // Map fill. Target level idx is the first one whose equalized value div_q
  // exceeds v; p is the value of the level just below it.
  assign fill_go = (vptr < {1'b0, div_q});
  assign tail_go = (vptr < n_act);
  assign fv      = vptr[IDX_W-1:0];
  assign dj      = div_q - fv;
  assign dp      = fv - p;
  always_comb begin
    if (idx == '0) begin
      fill_val = '0;
    end else if (p == fv) begin
      fill_val = idx - IDX_W'(1);
    end else if (dj < dp) begin
      fill_val = idx;
    end else begin
      fill_val = idx - IDX_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    eq_we      = 1'b0;
    eq_waddr   = {1'b1, fv};
    eq_wdata   = fill_val;
    eq_raddr   = {1'b0, q_idx};
    div_start  = 1'b0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (acc && command == CMD_QUERY) begin
          if (range_bad) begin
            state_next = S_OUT;
          end else if (!tables_current) begin
            state_next = S_SUM_RD;
          end else if (!totals_ok) begin
            state_next = S_OUT;
          end else begin
            state_next = S_Q_RD1;
          end
        end
      end
      S_SUM_RD: state_next = S_SUM_ACC;
      S_SUM_ACC: begin
        if (last_idx && tbl) begin
          state_next = zero_tot ? S_OUT : S_EQ_RD;
        end else begin
          state_next = S_SUM_RD;
        end
      end
      S_EQ_RD:  state_next = S_EQ_ACC;
      S_EQ_ACC: state_next = S_EQ_MUL;
      S_EQ_MUL: state_next = S_EQ_START;
      S_EQ_START: begin
        div_start  = 1'b1;
        state_next = S_EQ_DIV;
      end
      S_EQ_DIV: begin
        if (div_done) begin
          if (!tbl) begin
            eq_we      = 1'b1;
            eq_waddr   = {1'b0, idx};
            eq_wdata   = div_q;
            state_next = S_EQ_RD;
          end else begin
            state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (fill_go) begin
          eq_we = 1'b1;
        end else if (last_idx) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_EQ_RD;
        end
      end
      S_TAIL: begin
        eq_wdata = nm1;
        if (tail_go) begin
          eq_we = 1'b1;
        end else begin
          state_next = S_Q_RD1;
        end
      end
      S_Q_RD1: state_next = S_Q_RD2;
      S_Q_RD2: begin
        // Second read: the map entry for the source's equalized value.
        eq_raddr   = {1'b1, eq_rd};
        state_next = S_Q_RD3;
      end
      S_Q_RD3: state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign eq_x    = XW'(q_v);
  assign match_x = XW'(eq_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      lvl_cfg        <= CFG_RESET;
      tables_current <= 1'b0;
      totals_ok      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        lvl_cfg        <= cfg_wdata;
        tables_current <= 1'b0;
      end
      if (cnt_we) begin
        tables_current <= 1'b0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            q_level    <= level;
            q_idx      <= IDX_W'(level);
            res_status <= range_bad ? ST_RANGE : (totals_ok ? ST_OK : ST_ZERO);
            res_eq     <= '0;
            res_match  <= '0;
            idx        <= '0;
            tbl        <= 1'b0;
            src_tot    <= '0;
            tgt_tot    <= '0;
          end
        end
        S_SUM_ACC: begin
          if (!tbl) begin
            src_tot <= src_tot + cnt_rd_x;
          end else begin
            tgt_tot <= tgt_sum;
          end
          if (last_idx) begin
            idx <= '0;
            tbl <= ~tbl;
            if (tbl) begin
              cum  <= '0;
              vptr <= '0;
              p    <= '0;
              if (zero_tot) begin
                tables_current <= 1'b1;
                totals_ok      <= 1'b0;
                res_status     <= ST_ZERO;
              end
            end
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_EQ_ACC: cum <= cum + cnt_rd_x;
        S_EQ_MUL: begin
          // Rounded level is floor((2*(L-1)*cum + total) / (2*total)).
          num <= NUM_W'({NUM_W'(nm1) * NUM_W'(cum), 1'b0}) +
                 NUM_W'(tbl ? tgt_tot : src_tot);
          den <= {tbl ? tgt_tot : src_tot, 1'b0};
        end
        S_EQ_DIV: begin
          if (div_done && !tbl) begin
            if (last_idx) begin
              idx <= '0;
              tbl <= 1'b1;
              cum <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_FILL: begin
          if (fill_go) begin
            vptr <= vptr + (IDX_W + 1)'(1);
          end else begin
            p <= div_q;
            if (!last_idx) begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_TAIL: begin
          if (tail_go) begin
            vptr <= vptr + (IDX_W + 1)'(1);
          end else begin
            tables_current <= 1'b1;
            totals_ok      <= 1'b1;
            res_status     <= ST_OK;
          end
        end
        S_Q_RD2: q_v <= eq_rd;
        S_Q_RD3: begin
          res_eq    <= eq_x[LEVEL_W-1:0];
          res_match <= match_x[LEVEL_W-1:0];
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            source_level    <= q_level;
            equalized_level <= res_eq;
            matched_level   <= res_match;
            status          <= res_status;
          end
        end
        default: ;
      endcase
    end
  end

  hmm_ram #(.AW(AW), .DW(COUNT_BITS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (count),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  // Lower half holds source equalized levels, upper half the level map.
  hmm_ram #(.AW(AW), .DW(IDX_W)) u_eq_ram (
    .clk   (clk),
    .we    (eq_we),
    .waddr (eq_waddr),
    .wdata (eq_wdata),
    .raddr (eq_raddr),
    .rdata (eq_rd)
  );

  hmm_div #(.NUM_W(NUM_W), .DEN_W(TOT_W + 1), .Q_W(IDX_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  // The tables only go stale through a bin write or a register write.
  a_stale_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(tables_current) |->
      $past(cfg_we || (in_valid && in_ready &&
                       (command == CMD_SRC || command == CMD_TGT))))
    else $error("tables marked stale without a write");

  // A result is only loaded from the output state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside the output state");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_EQ_DIV)
    else $error("divider finished outside the equalize pass");

endmodule

### design/hmm_ram.sv
// Simple dual-port synchronous RAM with a registered read.
module hmm_ram #(
  parameter int AW = 9,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/hmm_div.sv
// Restoring divider that produces one quotient bit per cycle.
module hmm_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 33,
  parameter int Q_W   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= NUM_W'(den) << (Q_W - 1);
        quo  <= '0;
        cnt  <= CNT_W'(Q_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo <= (quo << 1) | Q_W'(ge);
        dsh <= dsh >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
